/* design/bnfsa_pkg.sv */
// ----------------------------------------------------------------------------
// bnfsa_pkg
// Shared types and codes for the bitmap next-fit slot allocator.
// ----------------------------------------------------------------------------
package bnfsa_pkg;

   // occupancy bitmap is stored as words of this many slots
   localparam int WordBits = 32;
   localparam int LaneBits = 5;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_DELETE = 2'd1;
   localparam func_type FUNC_QUERY  = 2'd2;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_RANGE     = 2'd2;
   localparam status_type STATUS_NOT_VALID = 2'd3;

endpackage

/* design/bitmap_next_fit_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_next_fit_slot_allocator_unit
// Slot allocator over an occupancy bitmap held in a word-wide memory.
//
// A command transaction is taken when start is high and busy is low. Insert
// claims the first clear slot at or after the next-free pointer (wrapping at
// the size in use), growing the size in use when there is no hole. Delete
// clears an occupied slot, query reports its bit. Every transaction returns
// one result on the rsp_ ports, marked by rsp_strobe for a single cycle; the
// receiver cannot stall it.
// Query and rejected delete read the slot's word; a good delete also reads
// the word under the next-free pointer, then clears the bit. Out-of-range
// commands and inserts into a full store are answered from idle without a
// memory read. Insert scans one bitmap word per cycle on the single memory
// port, at most ceil(CAPACITY/32)+1 words. busy stays high from acceptance
// until the result is registered, so the next transaction can be taken in
// the cycle the previous result is strobed. After reset the memory is
// cleared one word per cycle (ceil(CAPACITY/32) words); busy is high meanwhile.
// ----------------------------------------------------------------------------
module bitmap_next_fit_slot_allocator_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bnfsa_pkg::func_type    req_func,
   input  logic [9:0]             req_slot_index,
   input  logic                   req_batch_last,
   output logic                   rsp_strobe,
   output logic [9:0]             rsp_slot,
   output bnfsa_pkg::status_type  rsp_status,
   output logic                   rsp_is_valid,
   output logic [10:0]            rsp_count_valid,
   output logic [10:0]            rsp_size_in_use,
   output logic                   rsp_last
);
   import bnfsa_pkg::*;

   localparam int NumWords  = (CAPACITY + WordBits - 1) / WordBits;
   localparam int WAddrBits = (NumWords > 1) ? $clog2(NumWords) : 1;
   localparam int SlotBits  = WAddrBits + LaneBits;
   localparam int CountBits = SlotBits + 1;
   localparam int CmpBits   = (CountBits > 11) ? CountBits : 11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_SCAN,
      ST_IDX_CHK,
      ST_NF_CHK
   } state_type;

   state_type               state_ff, state_in;
   logic [WAddrBits-1:0]    clr_addr_ff, clr_addr_in;
   func_type                func_ff, func_in;
   logic [SlotBits-1:0]     idx_ff, idx_in;
   logic [CountBits-1:0]    active_ff, active_in;
   logic [CountBits-1:0]    valid_ff, valid_in;
   logic [SlotBits-1:0]     next_free_ff, next_free_in;
   logic [WAddrBits-1:0]    word_addr_ff, word_addr_in;
   logic [LaneBits-1:0]     start_lane_ff, start_lane_in;
   logic                    first_ff, first_in;
   logic [WordBits-1:0]     idx_word_ff, idx_word_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [9:0]              rsp_slot_ff, rsp_slot_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_is_valid_ff, rsp_is_valid_in;
   logic [10:0]             rsp_count_ff, rsp_count_in;
   logic [10:0]             rsp_size_ff, rsp_size_in;
   logic                    rsp_last_ff, rsp_last_in;

   // occupancy memory, one read/write port, registered read
   logic [WordBits-1:0]     occ_mem_ff [NumWords];
   logic [WordBits-1:0]     mem_rdata_ff;
   logic [WAddrBits-1:0]    mem_addr;
   logic                    mem_we;
   logic [WordBits-1:0]     mem_wdata;

   // scan helpers
   logic [SlotBits-1:0]     req_slot;
   logic [SlotBits-1:0]     start_slot;
   logic [SlotBits-1:0]     last_slot;
   logic [WordBits-1:0]     free_mask;
   logic                    found;
   logic [LaneBits-1:0]     found_lane;
   logic [SlotBits-1:0]     pos;
   logic [CountBits-1:0]    pos_next;
   logic                    nf_hit;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem_ff[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= occ_mem_ff[mem_addr];
   end

   assign req_slot  = SlotBits'(req_slot_index);
   assign last_slot = SlotBits'(active_ff - CountBits'(1));

   // clear lanes inside the size in use, skipping lanes below the start
   // lane on the first visit of the start word
   always_comb begin
      for (int i = 0; i < WordBits; i++) begin
         free_mask[i] = ~mem_rdata_ff[i];
         if (first_ff && (LaneBits'(i) < start_lane_ff)) begin
            free_mask[i] = 1'b0;
         end
         if ((word_addr_ff == last_slot[SlotBits-1:LaneBits]) &&
             (LaneBits'(i) > last_slot[LaneBits-1:0])) begin
            free_mask[i] = 1'b0;
         end
      end
   end

   always_comb begin
      found      = 1'b0;
      found_lane = '0;
      for (int i = WordBits - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            found      = 1'b1;
            found_lane = LaneBits'(i);
         end
      end
   end

   assign pos      = {word_addr_ff, found_lane};
   assign pos_next = CountBits'(pos) + CountBits'(1);
   assign nf_hit   = (CountBits'(next_free_ff) < active_ff) &&
                     mem_rdata_ff[next_free_ff[LaneBits-1:0]];

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      func_in         = func_ff;
      idx_in          = idx_ff;
      active_in       = active_ff;
      valid_in        = valid_ff;
      next_free_in    = next_free_ff;
      word_addr_in    = word_addr_ff;
      start_lane_in   = start_lane_ff;
      first_in        = first_ff;
      idx_word_in     = idx_word_ff;
      start_slot      = '0;
      rsp_strobe_in   = 1'b0;
      rsp_slot_in     = rsp_slot_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_is_valid_in = rsp_is_valid_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_size_in     = rsp_size_ff;
      rsp_last_in     = rsp_last_ff;
      mem_addr        = word_addr_ff;
      mem_we          = 1'b0;
      mem_wdata       = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_addr    = clr_addr_ff;
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + WAddrBits'(1);
            if (clr_addr_ff == WAddrBits'(NumWords - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (valid_ff >= active_ff) begin
               active_in = active_ff + CountBits'(1);
            end
            start_slot = (CountBits'(next_free_ff) < active_in) ? next_free_ff : '0;
            mem_addr   = (req_func == FUNC_INSERT) ? start_slot[SlotBits-1:LaneBits]
                                                   : req_slot[SlotBits-1:LaneBits];
            if (!start) begin
               active_in = active_ff;
            end else begin
               func_in     = req_func;
               idx_in      = req_slot;
               rsp_last_in = req_batch_last;
               if (req_func == FUNC_INSERT) begin
                  if ((valid_ff >= active_ff) && (active_ff >= CountBits'(CAPACITY))) begin
                     active_in       = active_ff;
                     rsp_strobe_in   = 1'b1;
                     rsp_slot_in     = '0;
                     rsp_status_in   = STATUS_FULL;
                     rsp_is_valid_in = 1'b0;
                  end else begin
                     word_addr_in  = start_slot[SlotBits-1:LaneBits];
                     start_lane_in = start_slot[LaneBits-1:0];
                     first_in      = 1'b1;
                     state_in      = ST_INS_SCAN;
                  end
               end else begin
                  active_in = active_ff;
                  if (CmpBits'(req_slot_index) >= CmpBits'(active_ff)) begin
                     rsp_strobe_in   = 1'b1;
                     rsp_slot_in     = req_slot_index;
                     rsp_status_in   = STATUS_RANGE;
                     rsp_is_valid_in = 1'b0;
                  end else begin
                     state_in = ST_IDX_CHK;
                  end
               end
            end
         end
         ST_INS_SCAN: begin
            if (found) begin
               mem_addr        = word_addr_ff;
               mem_we          = 1'b1;
               mem_wdata       = mem_rdata_ff | (WordBits'(1) << found_lane);
               valid_in        = valid_ff + CountBits'(1);
               next_free_in    = (pos_next >= active_ff) ? '0 : SlotBits'(pos_next);
               rsp_strobe_in   = 1'b1;
               rsp_slot_in     = 10'(pos);
               rsp_status_in   = STATUS_OK;
               rsp_is_valid_in = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               // next word, wrapping at the size in use
               word_addr_in = (word_addr_ff == last_slot[SlotBits-1:LaneBits]) ? '0
                              : word_addr_ff + WAddrBits'(1);
               first_in     = 1'b0;
               mem_addr     = word_addr_in;
            end
         end
         ST_IDX_CHK: begin
            idx_word_in = mem_rdata_ff;
            rsp_slot_in = 10'(idx_ff);
            if (func_ff != FUNC_DELETE) begin
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = STATUS_OK;
               rsp_is_valid_in = mem_rdata_ff[idx_ff[LaneBits-1:0]];
               state_in        = ST_IDLE;
            end else if (!mem_rdata_ff[idx_ff[LaneBits-1:0]]) begin
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = STATUS_NOT_VALID;
               rsp_is_valid_in = 1'b0;
               state_in        = ST_IDLE;
            end else begin
               // fetch the word under the pointer
               mem_addr = next_free_ff[SlotBits-1:LaneBits];
               state_in = ST_NF_CHK;
            end
         end
         ST_NF_CHK: begin
            if (nf_hit) begin
               next_free_in = idx_ff;
            end
            mem_addr        = idx_ff[SlotBits-1:LaneBits];
            mem_we          = 1'b1;
            mem_wdata       = idx_word_ff & ~(WordBits'(1) << idx_ff[LaneBits-1:0]);
            valid_in        = valid_ff - CountBits'(1);
            rsp_strobe_in   = 1'b1;
            rsp_status_in   = STATUS_OK;
            rsp_is_valid_in = 1'b0;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_strobe_in) begin
         rsp_count_in = 11'(valid_in);
         rsp_size_in  = 11'(active_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         active_ff     <= '0;
         valid_ff      <= '0;
         next_free_ff  <= '0;
         first_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         active_ff     <= active_in;
         valid_ff      <= valid_in;
         next_free_ff  <= next_free_in;
         first_ff      <= first_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      func_ff         <= func_in;
      idx_ff          <= idx_in;
      word_addr_ff    <= word_addr_in;
      start_lane_ff   <= start_lane_in;
      idx_word_ff     <= idx_word_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_is_valid_ff <= rsp_is_valid_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_size_ff     <= rsp_size_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign busy            = reset | (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_is_valid    = rsp_is_valid_ff;
   assign rsp_count_valid = rsp_count_ff;
   assign rsp_size_in_use = rsp_size_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
